>>> rtl/core/hsl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hsl_pkg;

  // Field widths and input ranges
  localparam int unsigned HUE_W  = 9;
  localparam int unsigned PCT_W  = 7;
  localparam int unsigned CHAN_W = 8;

  localparam logic [HUE_W-1:0]  HUE_MAX  = 9'd360;
  localparam logic [PCT_W-1:0]  PCT_MAX  = 7'd100;
  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  localparam int unsigned FRAC_BITS_DEFAULT = 16;

  // Divisors that turn degrees and percent into fractions of one
  localparam int unsigned HUE_DIV = 360;
  localparam int unsigned PCT_DIV = 100;

  // Reciprocals for the remainder part of the conversion. The remainder
  // products stay below HUE_DIV * HUE_DIV and PCT_DIV * PCT_DIV, where the
  // truncated product with a rounded-up reciprocal equals the true quotient.
  localparam int unsigned HUE_REM_W       = 17;
  localparam int unsigned HUE_RECIP_SHIFT = 26;
  localparam int unsigned HUE_RECIP_W     = 18;
  localparam int unsigned HUE_RECIP       = ((2 ** HUE_RECIP_SHIFT) + HUE_DIV - 1) / HUE_DIV;
  localparam int unsigned HUE_QUOT_W      = 9;

  localparam int unsigned PCT_REM_W       = 14;
  localparam int unsigned PCT_RECIP_SHIFT = 21;
  localparam int unsigned PCT_RECIP_W     = 15;
  localparam int unsigned PCT_RECIP       = ((2 ** PCT_RECIP_SHIFT) + PCT_DIV - 1) / PCT_DIV;
  localparam int unsigned PCT_QUOT_W      = 7;

endpackage

`default_nettype wire

>>> rtl/core/hsl_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface hsl_in_if;
  logic                         valid;
  logic                         ready;
  logic [hsl_pkg::HUE_W-1:0]    hue_degrees;
  logic [hsl_pkg::PCT_W-1:0]    saturation_pct;
  logic [hsl_pkg::PCT_W-1:0]    lightness_pct;

  modport source (output valid, output hue_degrees, output saturation_pct,
                  output lightness_pct, input ready);
  modport sink   (input valid, input hue_degrees, input saturation_pct,
                  input lightness_pct, output ready);
endinterface

interface hsl_out_if;
  logic                         valid;
  logic                         ready;
  logic [hsl_pkg::CHAN_W-1:0]   red;
  logic [hsl_pkg::CHAN_W-1:0]   green;
  logic [hsl_pkg::CHAN_W-1:0]   blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

>>> rtl/core/hsl_fixin.sv
`timescale 1ns / 1ps
`default_nettype none

module hsl_fixin #(
  parameter int unsigned FRAC_BITS = hsl_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [hsl_pkg::HUE_W-1:0]   hue_i,
  input  logic [hsl_pkg::PCT_W-1:0]   sat_i,
  input  logic [hsl_pkg::PCT_W-1:0]   lit_i,
  output logic                        valid_o,
  output logic [FRAC_BITS:0]          h_o,
  output logic [FRAC_BITS:0]          s_o,
  output logic [FRAC_BITS:0]          l_o
);

  localparam int unsigned W   = FRAC_BITS + 1;
  localparam int unsigned HRW = hsl_pkg::HUE_REM_W;
  localparam int unsigned PRW = hsl_pkg::PCT_REM_W;
  localparam int unsigned HCW = hsl_pkg::HUE_REM_W + hsl_pkg::HUE_RECIP_W;
  localparam int unsigned PCW = hsl_pkg::PCT_REM_W + hsl_pkg::PCT_RECIP_W;

  // one = 2^F split as DIV * whole + rem, per divisor
  localparam int unsigned HueWhole = (2 ** FRAC_BITS) / hsl_pkg::HUE_DIV;
  localparam int unsigned HueRem   = (2 ** FRAC_BITS) % hsl_pkg::HUE_DIV;
  localparam int unsigned PctWhole = (2 ** FRAC_BITS) / hsl_pkg::PCT_DIV;
  localparam int unsigned PctRem   = (2 ** FRAC_BITS) % hsl_pkg::PCT_DIV;

  localparam logic [HCW-1:0] HueRecip = HCW'(hsl_pkg::HUE_RECIP);
  localparam logic [PCW-1:0] PctRecip = PCW'(hsl_pkg::PCT_RECIP);

  logic [hsl_pkg::HUE_W-1:0] hue_c;
  logic [hsl_pkg::PCT_W-1:0] sat_c, lit_c;

  logic           v1_q, v2_q;
  logic [W-1:0]   hue_base_d, sat_base_d, lit_base_d;
  logic [W-1:0]   hue_base_q, sat_base_q, lit_base_q;
  logic [HRW-1:0] hue_rem_d, hue_rem_q;
  logic [PRW-1:0] sat_rem_d, sat_rem_q, lit_rem_d, lit_rem_q;

  logic [HCW-1:0] hue_prod;
  logic [PCW-1:0] sat_prod, lit_prod;
  logic [W-1:0]   h_d, s_d, l_d;
  logic [W-1:0]   h_q, s_q, l_q;

  // Stage 1: saturate, then split into whole and remainder products
  always_comb begin
    hue_c = (hue_i > hsl_pkg::HUE_MAX) ? hsl_pkg::HUE_MAX : hue_i;
    sat_c = (sat_i > hsl_pkg::PCT_MAX) ? hsl_pkg::PCT_MAX : sat_i;
    lit_c = (lit_i > hsl_pkg::PCT_MAX) ? hsl_pkg::PCT_MAX : lit_i;

    hue_base_d = W'(32'(hue_c) * HueWhole);
    sat_base_d = W'(32'(sat_c) * PctWhole);
    lit_base_d = W'(32'(lit_c) * PctWhole);
    hue_rem_d  = HRW'(32'(hue_c) * HueRem);
    sat_rem_d  = PRW'(32'(sat_c) * PctRem);
    lit_rem_d  = PRW'(32'(lit_c) * PctRem);
  end

  // Stage 2: divide the remainder products by reciprocal multiply
  always_comb begin
    hue_prod = HCW'(hue_rem_q) * HueRecip;
    sat_prod = PCW'(sat_rem_q) * PctRecip;
    lit_prod = PCW'(lit_rem_q) * PctRecip;
    h_d = hue_base_q + W'(hue_prod[hsl_pkg::HUE_RECIP_SHIFT +: hsl_pkg::HUE_QUOT_W]);
    s_d = sat_base_q + W'(sat_prod[hsl_pkg::PCT_RECIP_SHIFT +: hsl_pkg::PCT_QUOT_W]);
    l_d = lit_base_q + W'(lit_prod[hsl_pkg::PCT_RECIP_SHIFT +: hsl_pkg::PCT_QUOT_W]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hue_base_q <= hue_base_d;
      sat_base_q <= sat_base_d;
      lit_base_q <= lit_base_d;
      hue_rem_q  <= hue_rem_d;
      sat_rem_q  <= sat_rem_d;
      lit_rem_q  <= lit_rem_d;
      h_q        <= h_d;
      s_q        <= s_d;
      l_q        <= l_d;
    end
  end

  assign valid_o = v2_q;
  assign h_o     = h_q;
  assign s_o     = s_q;
  assign l_o     = l_q;

endmodule

`default_nettype wire

>>> rtl/core/hsl_level.sv
`timescale 1ns / 1ps
`default_nettype none

module hsl_level #(
  parameter int unsigned FRAC_BITS = hsl_pkg::FRAC_BITS_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [FRAC_BITS:0] h_i,
  input  logic [FRAC_BITS:0] s_i,
  input  logic [FRAC_BITS:0] l_i,
  output logic               valid_o,
  output logic [FRAC_BITS:0] x_o,
  output logic [FRAC_BITS:0] y_o,
  output logic [FRAC_BITS:0] d_o,
  output logic [FRAC_BITS:0] ph_r_o,
  output logic [FRAC_BITS:0] ph_g_o,
  output logic [FRAC_BITS:0] ph_b_o
);

  localparam int unsigned W = FRAC_BITS + 1;
  localparam logic [W-1:0] One   = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [W-1:0] Third = W'((2 ** FRAC_BITS) / 3);

  logic           v3_q, v4_q;
  logic [2*W-1:0] ls_full;
  logic [W-1:0]   prod_d;
  logic [W-1:0]   h3_q, s3_q, l3_q, prod3_q;

  logic           lo_half;
  logic [W:0]     y_sum;
  logic signed [W+1:0] x_diff;
  logic [W-1:0]   x_d, y_d, d_d;
  logic [W:0]     r_sum;
  logic [W-1:0]   pr_d, pb_d;
  logic [W-1:0]   x_q, y_q, d_q, pr_q, pg_q, pb_q;

  // Stage 3: lightness times saturation
  always_comb begin
    ls_full = (2*W)'(l_i) * (2*W)'(s_i);
    prod_d  = ls_full[FRAC_BITS +: W];
  end

  // Stage 4: upper and lower levels, channel phases
  always_comb begin
    lo_half = (l3_q[FRAC_BITS -: 2] == 2'b00);
    if (lo_half) begin
      y_sum = {1'b0, l3_q} + {1'b0, prod3_q};
    end else begin
      y_sum = {1'b0, l3_q} + {1'b0, s3_q} - {1'b0, prod3_q};
    end
    x_diff = $signed({1'b0, l3_q, 1'b0}) - $signed({1'b0, y_sum});
    x_d    = x_diff[W+1] ? '0 : x_diff[W-1:0];
    y_d    = y_sum[W-1:0];
    if (y_d < x_d) begin
      y_d = x_d;
    end
    d_d = y_d - x_d;

    // red leads by a third and wraps past one; blue trails and wraps below zero
    r_sum = {1'b0, h3_q} + {1'b0, Third};
    pr_d  = (r_sum > {1'b0, One}) ? W'(r_sum - {1'b0, One}) : r_sum[W-1:0];
    pb_d  = (h3_q < Third) ? (h3_q + One - Third) : (h3_q - Third);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= valid_i;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h3_q    <= h_i;
      s3_q    <= s_i;
      l3_q    <= l_i;
      prod3_q <= prod_d;
      x_q     <= x_d;
      y_q     <= y_d;
      d_q     <= d_d;
      pr_q    <= pr_d;
      pg_q    <= h3_q;
      pb_q    <= pb_d;
    end
  end

  assign valid_o = v4_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign d_o     = d_q;
  assign ph_r_o  = pr_q;
  assign ph_g_o  = pg_q;
  assign ph_b_o  = pb_q;

endmodule

`default_nettype wire

>>> rtl/core/hsl_ramp.sv
`timescale 1ns / 1ps
`default_nettype none

module hsl_ramp #(
  parameter int unsigned FRAC_BITS = hsl_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [FRAC_BITS:0]          phase_i,
  input  logic [FRAC_BITS:0]          x_i,
  input  logic [FRAC_BITS:0]          y_i,
  input  logic [FRAC_BITS:0]          d_i,
  output logic                        valid_o,
  output logic [hsl_pkg::CHAN_W-1:0]  chan_o
);

  localparam int unsigned W = FRAC_BITS + 1;
  localparam int unsigned CW = hsl_pkg::CHAN_W;

  localparam logic [W-1:0]   One      = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [W-1:0]   TwoThird = W'((2 ** (FRAC_BITS + 1)) / 3);
  localparam logic [W+2:0]   OneX6    = (W+3)'(One);
  localparam logic [W:0]     OneX2    = (W+1)'(One);
  localparam logic [W+1:0]   TwoOne   = {2'b01, {(W){1'b0}}};

  typedef enum logic [1:0] {
    RampRise,
    RampHigh,
    RampFall,
    RampLow
  } ramp_mode_e;

  logic [W+2:0] p6, fall6;
  logic [W:0]   p2;
  logic [W+1:0] p3;
  ramp_mode_e   mode_d, mode_q;
  logic [W-1:0] m_d, m_q;
  logic [W-1:0] xa_q, ya_q, da_q;

  logic [2*W-1:0] dm;
  logic [W:0]     lvl_d, lvl_q;

  logic [W+CW:0]  scaled;
  logic [CW:0]    chan_full;
  logic [CW-1:0]  chan_d, chan_q;

  logic va_q, vb_q, vc_q;

  // Stage A: locate the phase on the ramp and pick the multiplier operand
  always_comb begin
    p6    = (W+3)'(phase_i) * (W+3)'(6);
    p2    = {phase_i, 1'b0};
    p3    = (W+2)'(phase_i) * (W+2)'(3);
    fall6 = (W+3)'(TwoThird - phase_i) * (W+3)'(6);
    m_d   = '0;
    if (p6 < OneX6) begin
      mode_d = RampRise;
      m_d    = p6[W-1:0];
    end else if (p2 < OneX2) begin
      mode_d = RampHigh;
    end else if (p3 < TwoOne) begin
      mode_d = RampFall;
      m_d    = fall6[W-1:0];
    end else begin
      mode_d = RampLow;
    end
  end

  // Stage B: level = lower + span * operand, or the upper level while high
  always_comb begin
    dm = (2*W)'(da_q) * (2*W)'(m_q);
    case (mode_q)
      RampRise, RampFall: lvl_d = {1'b0, xa_q} + {1'b0, dm[FRAC_BITS +: W]};
      RampHigh:           lvl_d = {1'b0, ya_q};
      default:            lvl_d = {1'b0, xa_q};
    endcase
  end

  // Stage C: scale by 255, truncate, clamp
  always_comb begin
    scaled    = {lvl_q, {CW{1'b0}}} - (W+CW+1)'(lvl_q);
    chan_full = scaled[FRAC_BITS +: CW+1];
    chan_d    = chan_full[CW] ? hsl_pkg::CHAN_MAX : chan_full[CW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode_q <= mode_d;
      m_q    <= m_d;
      xa_q   <= x_i;
      ya_q   <= y_i;
      da_q   <= d_i;
      lvl_q  <= lvl_d;
      chan_q <= chan_d;
    end
  end

  assign valid_o = vc_q;
  assign chan_o  = chan_q;

endmodule

`default_nettype wire

>>> rtl/core/hsl_to_rgb_converter.sv
// Throughput: one color per cycle; a new transfer is taken every cycle unless
//   the output holds a result that the sink has not taken.
// The seven stages: two for the percent/degree to fixed-point conversion, two
//   for the upper/lower levels and phases, three for each channel ramp.
// Reset (rst_ni low, asynchronous) empties the pipeline; data registers keep junk.
`timescale 1ns / 1ps
`default_nettype none

module hsl_to_rgb_converter #(
  parameter int unsigned FRAC_BITS = hsl_pkg::FRAC_BITS_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hsl_in_if.sink     hsl_in_i,
  hsl_out_if.source  rgb_out_o
);

  localparam int unsigned W = FRAC_BITS + 1;

  // Global advance: the whole pipeline moves unless the output register is
  // full and the sink is stalling. Bubbles move along with items, so nothing
  // is dropped or repeated during a stall.
  logic en;
  logic out_valid;

  // Fixed-point hue, saturation, lightness
  logic         fix_valid;
  logic [W-1:0] fix_h, fix_s, fix_l;

  // Upper/lower levels and per-channel phases
  logic         lvl_valid;
  logic [W-1:0] lvl_x, lvl_y, lvl_d;
  logic [W-1:0] ph_r, ph_g, ph_b;

  logic r_valid, g_valid, b_valid;
  logic [hsl_pkg::CHAN_W-1:0] red_c, green_c, blue_c;

  assign en             = !out_valid || rgb_out_o.ready;
  assign hsl_in_i.ready = en;

  // Stages 1-2: saturate inputs and convert to fractions of one
  hsl_fixin #(
    .FRAC_BITS (FRAC_BITS)
  ) u_fixin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (hsl_in_i.valid),
    .hue_i   (hsl_in_i.hue_degrees),
    .sat_i   (hsl_in_i.saturation_pct),
    .lit_i   (hsl_in_i.lightness_pct),
    .valid_o (fix_valid),
    .h_o     (fix_h),
    .s_o     (fix_s),
    .l_o     (fix_l)
  );

  // Stages 3-4: upper level, lower level, span and wrapped phases
  hsl_level #(
    .FRAC_BITS (FRAC_BITS)
  ) u_level (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fix_valid),
    .h_i     (fix_h),
    .s_i     (fix_s),
    .l_i     (fix_l),
    .valid_o (lvl_valid),
    .x_o     (lvl_x),
    .y_o     (lvl_y),
    .d_o     (lvl_d),
    .ph_r_o  (ph_r),
    .ph_g_o  (ph_g),
    .ph_b_o  (ph_b)
  );

  // Stages 5-7: one ramp per channel, red leads by a third, blue trails
  hsl_ramp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ramp_r (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (lvl_valid),
    .phase_i (ph_r),
    .x_i     (lvl_x),
    .y_i     (lvl_y),
    .d_i     (lvl_d),
    .valid_o (r_valid),
    .chan_o  (red_c)
  );

  hsl_ramp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ramp_g (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (lvl_valid),
    .phase_i (ph_g),
    .x_i     (lvl_x),
    .y_i     (lvl_y),
    .d_i     (lvl_d),
    .valid_o (g_valid),
    .chan_o  (green_c)
  );

  hsl_ramp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ramp_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (lvl_valid),
    .phase_i (ph_b),
    .x_i     (lvl_x),
    .y_i     (lvl_y),
    .d_i     (lvl_d),
    .valid_o (b_valid),
    .chan_o  (blue_c)
  );

  // The last ramp stage is the output register
  assign out_valid       = r_valid && g_valid && b_valid;
  assign rgb_out_o.valid = out_valid;
  assign rgb_out_o.red   = red_c;
  assign rgb_out_o.green = green_c;
  assign rgb_out_o.blue  = blue_c;

  // The three channel pipelines share one advance and must stay in lockstep
  a_lanes_lockstep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (r_valid == g_valid) && (g_valid == b_valid))
    else $error("channel pipelines out of step");

  // A stalled pipeline must hold the fixin, level and output valid bits
  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(fix_valid) && $stable(lvl_valid) && $stable(out_valid)))
    else $error("pipeline moved during a stall");

  // Lower level never exceeds the upper level
  a_level_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_valid |-> (lvl_x <= lvl_y))
    else $error("lower level above upper level");

  // Any transfer in a cycle with a full output register must see the sink take it
  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hsl_in_i.valid && hsl_in_i.ready && out_valid) |-> rgb_out_o.ready)
    else $error("input taken while output stalled");

endmodule

`default_nettype wire
